// File: rtl/hacdr_pkg.sv
// Package for the head angle center/drift response block.
// Shared widths, register indexes, lane control types. No dependencies.
package hacdr_pkg;

  localparam int unsigned NUM_AXES       = 3;
  localparam int unsigned ANG_W          = 16;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned MUL_W          = 2 * ANG_W;

  // Must stay a power of two: the average is an arithmetic shift.
  localparam int unsigned CENTER_SAMPLES = 8;
  localparam int unsigned CENTER_SHIFT   = $clog2(CENTER_SAMPLES);

  localparam int unsigned DRIFT_SHIFT    = 10;
  localparam int unsigned CURVE_SHIFT    = 13;
  localparam int unsigned DRIFT_PROD_W   = DRIFT_SHIFT + ANG_W;
  localparam int unsigned SQ_W           = 2 * ANG_W + 1;

  localparam int unsigned AXIS_YAW       = 0;

  localparam logic [CNT_W-1:0] CNT_INIT  = CNT_W'(-CENTER_SAMPLES);

  localparam logic signed [MUL_W-1:0] PROD_MAX = MUL_W'(32767);
  localparam logic signed [MUL_W-1:0] PROD_MIN = -MUL_W'(32768);
  localparam logic [ANG_W-1:0]        SAT_MAX  = 16'h7FFF;
  localparam logic [ANG_W-1:0]        SAT_MIN  = 16'h8000;

  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LINEAR_MODE = 3'd0;
  localparam cfg_idx_t REG_YAW_DRIFT   = 3'd1;
  localparam cfg_idx_t REG_GAIN_YAW    = 3'd2;
  localparam cfg_idx_t REG_GAIN_ROLL   = 3'd3;
  localparam cfg_idx_t REG_GAIN_PITCH  = 3'd4;

  typedef logic [NUM_AXES-1:0][ANG_W-1:0] ang_vec_t;

  typedef struct packed {
    logic start;
    logic hold;
  } lane_ctl_t;

  typedef struct packed {
    logic b_vld;
    logic c_vld;
  } lane_stat_t;

endpackage

// File: rtl/hacdr_if.sv
// Channel interfaces: input samples, result angles, register writes.
// Depends on hacdr_pkg.
interface hacdr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [hacdr_pkg::ANG_W-1:0] yaw_angle;
  logic signed [hacdr_pkg::ANG_W-1:0] roll_angle;
  logic signed [hacdr_pkg::ANG_W-1:0] pitch_angle;
  logic                              recenter_request;

  modport source (output valid, yaw_angle, roll_angle, pitch_angle, recenter_request,
                  input ready);
  modport sink   (input valid, yaw_angle, roll_angle, pitch_angle, recenter_request,
                  output ready);
endinterface

interface hacdr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hacdr_pkg::ANG_W-1:0] out_yaw;
  logic signed [hacdr_pkg::ANG_W-1:0] out_roll;
  logic signed [hacdr_pkg::ANG_W-1:0] out_pitch;

  modport source (output valid, out_yaw, out_roll, out_pitch, input ready);
  modport sink   (input valid, out_yaw, out_roll, out_pitch, output ready);
endinterface

interface hacdr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hacdr_pkg::CFG_IDX_W-1:0] reg_index;
  logic [hacdr_pkg::ANG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/head_angle_center_drift_response.sv
// Top level: registers, drift product, lanes and merge stage.
// Depends on hacdr_pkg, hacdr_if, hacdr_center, hacdr_lane, hacdr_merge.
//
//  channel | dir | payload                                        | handshake
//  in_i    | in  | yaw/roll/pitch_angle, recenter_request         | valid/ready
//  out_o   | out | out_yaw, out_roll, out_pitch                   | valid/ready
//  cfg_i   | in  | reg_index, wdata                               | valid/ready
//
// A sample passes the center register, the drift stage, two lane stages and
// the merge register; a new one is taken only once it has left the first lane
// stage. Samples before the center is ready give
// no result. Reset starts a centering. A held result does not block the
// next transfer; a result stalled behind it holds the lanes and input.
// Register writes are always taken.
module head_angle_center_drift_response (
  input  logic         clk_i,
  input  logic         rst_ni,
  hacdr_in_if.sink     in_i,
  hacdr_out_if.source  out_o,
  hacdr_cfg_if.sink    cfg_i
);
  import hacdr_pkg::*;

  logic                   linear_q;
  logic [ANG_W-1:0]       drift_cfg_q;
  ang_vec_t               gain_q;

  logic                   accept;
  ang_vec_t               ang;
  ang_vec_t               x;
  logic [DRIFT_PROD_W-1:0] cnt;
  logic                   ctr_vld;

  logic signed [DRIFT_PROD_W-1:0] drift_prod;
  logic [ANG_W-1:0]       drift_q;
  logic                   s2_q;

  lane_ctl_t              lane_ctl;
  lane_stat_t             lane_stat [NUM_AXES];
  logic [NUM_AXES-1:0]    done;
  ang_vec_t               res;
  logic                   stall;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_q    <= 1'b1;
      drift_cfg_q <= '0;
      gain_q      <= {NUM_AXES{ANG_W'(1)}};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_LINEAR_MODE: linear_q    <= cfg_i.wdata[0];
        REG_YAW_DRIFT:   drift_cfg_q <= cfg_i.wdata;
        REG_GAIN_YAW:    gain_q[0]   <= cfg_i.wdata;
        REG_GAIN_ROLL:   gain_q[1]   <= cfg_i.wdata;
        REG_GAIN_PITCH:  gain_q[2]   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign in_i.ready = ~(ctr_vld | s2_q | lane_stat[0].b_vld)
                      & ~(lane_stat[0].c_vld & stall);
  assign accept     = in_i.valid & in_i.ready;
  assign ang        = {in_i.pitch_angle, in_i.roll_angle, in_i.yaw_angle};

  hacdr_center u_center (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ang_i      (ang),
    .recenter_i (in_i.recenter_request),
    .x_o        (x),
    .cnt_o      (cnt),
    .vld_o      (ctr_vld)
  );

  // low bits of counter * drift; only bits up to the shifted field matter
  assign drift_prod = $signed(cnt) * $signed(drift_cfg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
    end else begin
      s2_q <= ctr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctr_vld) begin
      drift_q <= drift_prod[DRIFT_PROD_W-1:DRIFT_SHIFT];
    end
  end

  assign lane_ctl.start = s2_q;
  assign lane_ctl.hold  = stall;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    hacdr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .x_i      (x[a]),
      .sub_i    ((a == AXIS_YAW) ? drift_q : ANG_W'(0)),
      .linear_i (linear_q),
      .gain_i   (gain_q[a]),
      .stat_o   (lane_stat[a]),
      .res_o    (res[a])
    );
    assign done[a] = lane_stat[a].c_vld;
  end

  hacdr_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .done_i  (done),
    .res_i   (res),
    .stall_o (stall),
    .out_o   (out_o)
  );

endmodule

// File: rtl/hacdr_center.sv
// Recenter control, sample counter and wrap-biased center averaging.
// Produces the centered angles of each accepted sample. Depends on hacdr_pkg.
module hacdr_center (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  hacdr_pkg::ang_vec_t          ang_i,
  input  logic                         recenter_i,
  output hacdr_pkg::ang_vec_t          x_o,
  output logic [hacdr_pkg::DRIFT_PROD_W-1:0] cnt_o,
  output logic                         vld_o
);
  import hacdr_pkg::*;

  logic                 pend_q;
  logic                 rdy_q, rdy_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  ang_vec_t             ctr_q, ctr_d;
  ang_vec_t             ref_q, ref_d;
  ang_vec_t             x_q, x_d;
  logic                 vld_q;

  always_comb begin
    logic             pend_eff;
    logic             rdy_base;
    logic             wrap;
    logic [ANG_W-1:0] acc;
    pend_eff = pend_q | recenter_i;
    cnt_d    = (pend_eff ? CNT_INIT : cnt_q) + CNT_W'(1);
    rdy_base = pend_eff ? 1'b0 : rdy_q;
    wrap     = (cnt_d == '0);
    for (int a = 0; a < NUM_AXES; a++) begin
      ref_d[a] = pend_eff ? ang_i[a] : ref_q[a];
      acc      = pend_eff ? '0 : ctr_q[a];
      if (!rdy_base) begin
        acc = acc + ang_i[a] - ref_d[a];
      end
      if (wrap) begin
        acc = ANG_W'($signed(acc) >>> CENTER_SHIFT) + ref_d[a];
      end
      ctr_d[a] = acc;
      x_d[a]   = ang_i[a] - acc;
    end
    rdy_d = rdy_base | wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      rdy_q  <= 1'b0;
      cnt_q  <= '0;
      ctr_q  <= '0;
      ref_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      vld_q <= accept_i & rdy_d;
      if (accept_i) begin
        pend_q <= 1'b0;
        rdy_q  <= rdy_d;
        cnt_q  <= cnt_d;
        ctr_q  <= ctr_d;
        ref_q  <= ref_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x_q <= x_d;
    end
  end

  assign x_o   = x_q;
  assign cnt_o = cnt_q[DRIFT_PROD_W-1:0];
  assign vld_o = vld_q;

endmodule

// File: rtl/hacdr_lane.sv
// One axis lane: drift subtract, x*|x| curve, gain multiply, saturation.
// Two register stages. Depends on hacdr_pkg.
module hacdr_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hacdr_pkg::lane_ctl_t        ctl_i,
  input  logic [hacdr_pkg::ANG_W-1:0] x_i,
  input  logic [hacdr_pkg::ANG_W-1:0] sub_i,
  input  logic                        linear_i,
  input  logic [hacdr_pkg::ANG_W-1:0] gain_i,
  output hacdr_pkg::lane_stat_t       stat_o,
  output logic [hacdr_pkg::ANG_W-1:0] res_o
);
  import hacdr_pkg::*;

  logic                    vb_q, vc_q;
  logic                    hold;
  logic [ANG_W-1:0]        y_d, y_q;
  logic [ANG_W:0]          ay;
  logic signed [SQ_W-1:0]  sq_d, sq_q;
  logic [ANG_W-1:0]        shaped;
  logic signed [MUL_W-1:0] p_d, p_q;

  // the lane holds only while a finished result waits; both stages then hold
  assign hold = ctl_i.hold & vc_q;

  assign y_d  = x_i - sub_i;
  assign ay   = y_d[ANG_W-1] ? ((ANG_W+1)'(0) - {y_d[ANG_W-1], y_d}) : {1'b0, y_d};
  assign sq_d = $signed(y_d) * $signed({1'b0, ay});

  assign shaped = linear_i ? y_q : sq_q[CURVE_SHIFT+ANG_W-1:CURVE_SHIFT];
  assign p_d    = $signed(shaped) * $signed(gain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (!hold) begin
      vb_q <= ctl_i.start;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold) begin
      if (ctl_i.start) begin
        y_q  <= y_d;
        sq_q <= sq_d;
      end
      if (vb_q) begin
        p_q <= p_d;
      end
    end
  end

  always_comb begin
    if (p_q > PROD_MAX) begin
      res_o = SAT_MAX;
    end else if (p_q < PROD_MIN) begin
      res_o = SAT_MIN;
    end else begin
      res_o = p_q[ANG_W-1:0];
    end
  end

  assign stat_o.b_vld = vb_q;
  assign stat_o.c_vld = vc_q;

endmodule

// File: rtl/hacdr_merge.sv
// Merge stage: joins the lane results into the output register.
// Drives the result channel. Depends on hacdr_pkg, hacdr_if.
module hacdr_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hacdr_pkg::NUM_AXES-1:0] done_i,
  input  hacdr_pkg::ang_vec_t          res_i,
  output logic                         stall_o,
  hacdr_out_if.source                  out_o
);
  import hacdr_pkg::*;

  logic     vld_q;
  ang_vec_t res_q;
  logic     load;

  assign stall_o = vld_q & ~out_o.ready;
  assign load    = (&done_i) & ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid     = vld_q;
  assign out_o.out_yaw   = res_q[0];
  assign out_o.out_roll  = res_q[1];
  assign out_o.out_pitch = res_q[2];

endmodule

// File: rtl/hacdr_chk.sv
// Port-level checker for the top level, attached by bind.
// Depends on the top level's channel interfaces only through the bind.
module hacdr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_yaw_i,
  input logic [15:0] out_roll_i,
  input logic [15:0] out_pitch_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i & in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_yaw_i)
      && $stable(out_roll_i) && $stable(out_pitch_i))
    else $error("result changed while stalled");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({out_yaw_i, out_roll_i, out_pitch_i}))
    else $error("result payload unknown while valid");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 5))
    else $error("result without a transfer five cycles earlier");

endmodule

bind head_angle_center_drift_response hacdr_chk u_hacdr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_yaw_i   (out_o.out_yaw),
  .out_roll_i  (out_o.out_roll),
  .out_pitch_i (out_o.out_pitch)
);

// File: test/tb.sv
// Testbench for head_angle_center_drift_response: directed and random samples,
// a local prediction of centering, drift, curve and gain, in-order result checks.
// Depends on hacdr_pkg, hacdr_if and the RTL of the block.
module tb;
  import hacdr_pkg::*;

  localparam int            SETTLE_CYCLES    = 16;
  localparam int            RANDOM_PER_PHASE = 160;
  localparam int            NUM_SETTINGS     = 6;
  localparam int            HOLD_AT_RESULT   = 120;
  localparam int            HOLD_CYCLES      = 250;
  localparam int            WATCHDOG_LIMIT   = 2000;
  localparam int            MAX_REPORTS      = 10;
  localparam cfg_idx_t      UNUSED_REG_IDX   = 3'd7;

  typedef struct packed {
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic                    recenter;
  } angle_sample_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
  } head_pose_t;

  logic clk;
  logic rst_n = 1'b0;

  hacdr_in_if  in_ch ();
  hacdr_out_if out_ch ();
  hacdr_cfg_if cfg_ch ();

  head_angle_center_drift_response uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // register shadow
  bit                      linear_on    = 1'b1;
  logic signed [ANG_W-1:0] yaw_drift_rate = '0;
  logic signed [ANG_W-1:0] gain_axis [NUM_AXES] = '{16'sd1, 16'sd1, 16'sd1};

  // centering state
  bit                      recenter_due = 1'b1;
  bit                      centered     = 1'b0;
  logic [CNT_W-1:0]        pred_count   = '0;
  logic [ANG_W-1:0]        center_pos [NUM_AXES] = '{default: '0};
  logic [ANG_W-1:0]        wrap_ref   [NUM_AXES] = '{default: '0};

  angle_sample_t pending_samples [$];
  head_pose_t    expected_poses  [$];
  angle_sample_t cur_sample;
  logic [ANG_W-1:0] motion_base [NUM_AXES];

  int  items_sent     = 0;
  int  items_taken    = 0;
  int  results_seen   = 0;
  int  err_count      = 0;
  int  reg_writes     = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  tx_steady      = 1'b0;
  bit  rx_steady      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit predict_pose(input angle_sample_t s, output head_pose_t r);
    logic signed [ANG_W-1:0] ang [NUM_AXES];
    logic signed [ANG_W-1:0] avg;
    logic signed [47:0]      drift_prod;
    int                      v;
    int                      sq;
    int                      p;
    ang[0] = s.yaw;
    ang[1] = s.roll;
    ang[2] = s.pitch;
    if (s.recenter) recenter_due = 1'b1;
    if (recenter_due) begin
      pred_count   = CNT_INIT;
      recenter_due = 1'b0;
      centered     = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        wrap_ref[i]   = ang[i];
        center_pos[i] = '0;
      end
    end
    pred_count = pred_count + 1;
    if (!centered)
      for (int i = 0; i < NUM_AXES; i++) center_pos[i] = center_pos[i] + ang[i] - wrap_ref[i];
    if (pred_count == '0) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        avg           = $signed(center_pos[i]) >>> CENTER_SHIFT;
        center_pos[i] = avg + wrap_ref[i];
      end
      centered = 1'b1;
    end
    if (!centered) return 1'b0;
    for (int i = 0; i < NUM_AXES; i++) ang[i] = ang[i] - center_pos[i];
    drift_prod = $signed(pred_count) * yaw_drift_rate;
    ang[AXIS_YAW] = ang[AXIS_YAW] - drift_prod[25:10];
    if (!linear_on)
      for (int i = 0; i < NUM_AXES; i++) begin
        v      = ang[i];
        sq     = v * ((v < 0) ? -v : v);
        ang[i] = sq[28:13];
      end
    for (int i = 0; i < NUM_AXES; i++) begin
      p = int'(ang[i]) * int'(gain_axis[i]);
      if (p < -32768) p = -32768;
      else if (p > 32767) p = 32767;
      ang[i] = p[15:0];
    end
    r.yaw   = ang[0];
    r.roll  = ang[1];
    r.pitch = ang[2];
    return 1'b1;
  endfunction

  function automatic int draw_wait(bit steady);
    return steady ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic logic [ANG_W-1:0] pick_angle(int axis);
    int spread;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      1, 2: return 16'($urandom);
      default: begin
        spread = 1 << $urandom_range(0, 13);
        return motion_base[axis] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
      end
    endcase
  endfunction

  function automatic void queue_angles(logic [ANG_W-1:0] y, logic [ANG_W-1:0] r,
                                       logic [ANG_W-1:0] p, logic rc);
    angle_sample_t s;
    s.yaw      = y;
    s.roll     = r;
    s.pitch    = p;
    s.recenter = rc;
    pending_samples.push_back(s);
    items_sent++;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // sample transfers: prediction happens on acceptance
  always @(posedge clk or negedge rst_n) begin
    head_pose_t pose;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        items_taken++;
        if (predict_pose(cur_sample, pose)) expected_poses.push_back(pose);
        if ($urandom_range(0, 23) == 0) tx_steady = !tx_steady;
        gap_left = draw_wait(tx_steady);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          cur_sample = pending_samples.pop_front();
          in_ch.yaw_angle        <= cur_sample.yaw;
          in_ch.roll_angle       <= cur_sample.roll;
          in_ch.pitch_angle      <= cur_sample.pitch;
          in_ch.recenter_request <= cur_sample.recenter;
          in_ch.valid            <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result transfers: in-order compare, random stalls and one long hold-off
  always @(posedge clk or negedge rst_n) begin
    head_pose_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_poses.size() == 0) begin
          flag_error($sformatf("unexpected result yaw %0d roll %0d pitch %0d",
                               out_ch.out_yaw, out_ch.out_roll, out_ch.out_pitch));
        end else begin
          want = expected_poses.pop_front();
          if (out_ch.out_yaw !== want.yaw || out_ch.out_roll !== want.roll ||
              out_ch.out_pitch !== want.pitch)
            flag_error($sformatf({"mismatch: expected yaw %0d roll %0d pitch %0d,",
                                  " got yaw %0d roll %0d pitch %0d"},
                                 want.yaw, want.roll, want.pitch,
                                 out_ch.out_yaw, out_ch.out_roll, out_ch.out_pitch));
        end
        if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        stall_left = draw_wait(rx_steady);
      end
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [ANG_W-1:0] val);
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    cfg_ch.valid     <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_LINEAR_MODE: linear_on      = val[0];
      REG_YAW_DRIFT:   yaw_drift_rate = val;
      REG_GAIN_YAW:    gain_axis[0]   = val;
      REG_GAIN_ROLL:   gain_axis[1]   = val;
      REG_GAIN_PITCH:  gain_axis[2]   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [ANG_W-1:0] lin, logic [ANG_W-1:0] drift,
                           logic [ANG_W-1:0] gy, logic [ANG_W-1:0] gr,
                           logic [ANG_W-1:0] gp);
    write_reg(REG_LINEAR_MODE, lin);
    write_reg(REG_YAW_DRIFT, drift);
    write_reg(REG_GAIN_YAW, gy);
    write_reg(REG_GAIN_ROLL, gr);
    write_reg(REG_GAIN_PITCH, gp);
  endtask

  task automatic apply_setting(int k);
    case (k)
      0: write_all(16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
      1: write_all(16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      2: write_all(16'd1, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000);
      3: write_all(16'd0, 16'($urandom), 16'(int'($urandom_range(0, 16)) - 8),
                   16'(int'($urandom_range(0, 16)) - 8), 16'(int'($urandom_range(0, 16)) - 8));
      4: write_all(16'd1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: write_all(16'($urandom_range(0, 1)), 16'(int'($urandom_range(0, 64)) - 32),
                         16'd1, 16'hFFFF, 16'd2);
    endcase
  endtask

  task automatic drain(int settle);
    while (items_taken != items_sent || expected_poses.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("head_angle_center_drift_response test failed");
    $finish;
  end

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.yaw_angle        = '0;
    in_ch.roll_angle       = '0;
    in_ch.pitch_angle      = '0;
    in_ch.recenter_request = 1'b0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.reg_index       = '0;
    cfg_ch.wdata           = '0;
    foreach (motion_base[i]) motion_base[i] = 16'($urandom);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; centering straddles the wrap point
    queue_angles(16'sh7FFF, 16'sd0, -16'sd100, 1'b0);
    queue_angles(16'sh8000, 16'sd0, -16'sd101, 1'b0);
    queue_angles(16'sd32760, 16'sd5, 16'sh7FFF, 1'b0);
    queue_angles(-16'sd32760, -16'sd5, 16'sh8000, 1'b0);
    queue_angles(16'sd32700, 16'sd7, 16'sd0, 1'b0);
    queue_angles(-16'sd32700, -16'sd7, 16'sd1, 1'b0);
    queue_angles(16'sd100, 16'sd3, -16'sd1, 1'b0);
    queue_angles(-16'sd100, -16'sd3, 16'sd2, 1'b0);
    queue_angles(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    queue_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    queue_angles(16'sd0, -16'sd1, 16'sd1, 1'b0);
    // recenter, then recenter again before the centering completes
    queue_angles(16'sd1, 16'sd2, 16'sd3, 1'b1);
    queue_angles(16'sd5, 16'sd5, 16'sd5, 1'b1);
    drain(SETTLE_CYCLES);

    // curve on, extreme drift and gains; upper bits of linear_mode dropped
    write_all(16'hFFFE, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
    write_reg(UNUSED_REG_IDX, 16'h1234);
    queue_angles(16'sd0, 16'sd0, 16'sd0, 1'b1);
    repeat (7) queue_angles(16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_angles(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    queue_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    queue_angles(16'sd181, -16'sd181, 16'sd1000, 1'b0);
    queue_angles(-16'sd1, 16'sd1, -16'sd20000, 1'b0);
    drain(SETTLE_CYCLES);

    for (int k = 0; k < NUM_SETTINGS; k++) begin
      apply_setting(k);
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(0, 31) == 0) foreach (motion_base[i]) motion_base[i] = 16'($urandom);
        foreach (motion_base[i]) motion_base[i] = motion_base[i] + 16'($urandom_range(0, 64)) - 16'd32;
        queue_angles(pick_angle(0), pick_angle(1), pick_angle(2), $urandom_range(0, 29) == 0);
      end
      drain(SETTLE_CYCLES);
    end

    $display("Run covered %0d samples, %0d results and %0d register writes over %0d settings",
             items_taken, results_seen, reg_writes, NUM_SETTINGS + 2);
    $display("Errors found: %0d", err_count);
    if (err_count == 0 && expected_poses.size() == 0)
      $display("head_angle_center_drift_response test passed");
    else
      $display("head_angle_center_drift_response test failed");
    $finish;
  end

endmodule
